FILE: rtl/dtms_pkg.sv
// ----------------------------------------------------------------------------
// Token matching store package
// Shared types and constants for the dataflow token matching store.
// ----------------------------------------------------------------------------
package dtms_pkg;

  localparam int unsigned Entries    = 16;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned IdxBits    = 8;
  localparam int unsigned CtxBits    = 4;
  localparam int unsigned TagBits    = IdxBits + CtxBits;
  localparam int unsigned EntryBits  = $clog2(Entries);
  localparam int unsigned OccBits    = $clog2(Entries + 1);
  localparam int unsigned CapBits    = 5;
  localparam int unsigned AddrBits   = 2;

  // Operation codes.
  localparam logic OpAccept = 1'b0;
  localparam logic OpErase  = 1'b1;

  // Slot codes.
  localparam logic [1:0] SlotLeft  = 2'd0;
  localparam logic [1:0] SlotRight = 2'd1;
  localparam logic [1:0] SlotPred  = 2'd2;
  localparam logic [1:0] SlotNone  = 2'd3;

  // Register addresses.
  localparam logic [AddrBits-1:0] RegCapacity = 2'd0;
  localparam logic [CapBits-1:0]  CapReset    = 5'd16;

  typedef struct packed {
    logic                op;
    logic [1:0]          slot_position;
    logic [WordBits-1:0] token_value;
    logic [IdxBits-1:0]  instr_index;
    logic [CtxBits-1:0]  context_id;
  } in_item_t;

  typedef struct packed {
    logic                accepted;
    logic                left_valid;
    logic                right_valid;
    logic                pred_valid;
    logic [WordBits-1:0] left_value;
    logic [WordBits-1:0] right_value;
    logic [WordBits-1:0] pred_value;
    logic                store_empty;
    logic                store_full;
    logic                erase_missing;
  } out_item_t;

endpackage

FILE: rtl/dataflow_token_matching_store.sv
// ----------------------------------------------------------------------------
// Dataflow token matching store
// Tagged operand store that matches tokens by instruction index and context.
// ----------------------------------------------------------------------------
// Usage: pulse start_i with an item on item_i while busy_o is low. Tags and
// occupancy sit in flip-flops and are compared in parallel; the operand
// values sit in three synchronous memories with a registered read port.
// An item passes two steps: the tag lookup and the memory read in the first,
// the update and write-back in the second, after which done_o pulses for
// one cycle with the result on result_o. busy_o is high in the second step,
// so no item is taken during the memory read-modify-write. The receiver
// cannot stall; each result is shown once. Reset empties the store and sets
// the capacity register to 16; the value memories are not cleared, since a
// slot is only read behind its valid bit. The user writes the capacity
// register over the APB port only while the block idles; no logic enforces it.
// ----------------------------------------------------------------------------
module dataflow_token_matching_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  dtms_pkg::in_item_t                  item_i,
  output logic                                busy_o,
  output logic                                done_o,
  output dtms_pkg::out_item_t                 result_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dtms_pkg::AddrBits-1:0]       paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import dtms_pkg::*;

  logic [CapBits-1:0]   cap_q;
  logic [Entries-1:0]   used_q;
  logic [TagBits-1:0]   tag_q [Entries];
  logic [2:0]           sv_q [Entries];
  logic [OccBits-1:0]   occ_q;
  logic [WordBits-1:0]  lmem [Entries];
  logic [WordBits-1:0]  rmem [Entries];
  logic [WordBits-1:0]  pmem [Entries];
  logic [WordBits-1:0]  lrd_q, rrd_q, prd_q;

  // Stage registers.
  logic                 s1_q;
  in_item_t             it_q;
  logic                 hit_q, free_q;
  logic [EntryBits-1:0] idx_q;
  logic                 done_q;
  out_item_t            res_q;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == RegCapacity) ? {{(32-CapBits){1'b0}}, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (psel && penable && pwrite && paddr == RegCapacity) begin
      cap_q <= pwdata[CapBits-1:0];
    end
  end

  // Effective capacity, limited to the entry count.
  logic [CapBits-1:0] eff_cap;
  assign eff_cap = (cap_q > CapBits'(Entries)) ? CapBits'(Entries) : cap_q;

  // Lookup: parallel tag compare and lowest free entry.
  logic [TagBits-1:0]   tag_in;
  logic                 hit, free;
  logic [EntryBits-1:0] hit_idx, free_idx, look_idx;
  assign tag_in = {item_i.context_id, item_i.instr_index};

  always_comb begin
    hit = 1'b0; hit_idx = '0; free = 1'b0; free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (used_q[i] && tag_q[i] == tag_in) begin
        hit = 1'b1; hit_idx = EntryBits'(i);
      end
      if (!used_q[i]) begin
        free = 1'b1; free_idx = EntryBits'(i);
      end
    end
  end
  assign look_idx = hit ? hit_idx : free_idx;

  logic take;
  assign take   = start_i && !busy_o;
  assign busy_o = s1_q;

  // Memory read in the lookup cycle.
  always_ff @(posedge clk_i) begin
    if (take) begin
      lrd_q <= lmem[look_idx];
      rrd_q <= rmem[look_idx];
      prd_q <= pmem[look_idx];
      it_q  <= item_i;
      hit_q <= hit;
      free_q <= free;
      idx_q <= look_idx;
    end
  end

  // Update stage decisions.
  logic [2:0] sv_old;
  logic       is_acc, do_alloc, do_write, do_erase;
  logic [2:0] sv_new, sv_show;
  logic [OccBits-1:0] occ_new;
  assign sv_old   = hit_q ? sv_q[idx_q] : 3'b000;
  assign is_acc   = it_q.op == OpAccept && it_q.slot_position != SlotNone;
  assign do_alloc = is_acc && !hit_q && free_q &&
                    ({{(CapBits-OccBits){1'b0}}, occ_q} < eff_cap);
  assign do_write = is_acc && (hit_q || do_alloc);
  assign do_erase = it_q.op == OpErase && hit_q;
  assign sv_new   = sv_old | (3'b001 << it_q.slot_position);

  always_comb begin
    occ_new = occ_q;
    if (do_alloc) occ_new = occ_q + 1'b1;
    else if (do_erase) occ_new = occ_q - 1'b1;
    sv_show = 3'b000;
    if (do_write) sv_show = sv_new;
    else if (hit_q && !(is_acc)) sv_show = sv_old;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      done_q <= 1'b0;
      used_q <= '0;
      occ_q  <= '0;
      for (int i = 0; i < Entries; i++) sv_q[i] <= 3'b000;
    end else begin
      s1_q   <= take;
      done_q <= s1_q;
      if (s1_q) begin
        occ_q <= occ_new;
        if (do_alloc) used_q[idx_q] <= 1'b1;
        if (do_write) sv_q[idx_q] <= sv_new;
        if (do_erase) begin
          used_q[idx_q] <= 1'b0;
          sv_q[idx_q]   <= 3'b000;
        end
      end
    end
  end

  // Tag and value write-back.
  always_ff @(posedge clk_i) begin
    if (s1_q && do_alloc) tag_q[idx_q] <= {it_q.context_id, it_q.instr_index};
    if (s1_q && do_write) begin
      case (it_q.slot_position)
        SlotLeft:  lmem[idx_q] <= it_q.token_value;
        SlotRight: rmem[idx_q] <= it_q.token_value;
        default:   pmem[idx_q] <= it_q.token_value;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      res_q.accepted      <= do_write;
      res_q.left_valid    <= sv_show[0];
      res_q.right_valid   <= sv_show[1];
      res_q.pred_valid    <= sv_show[2];
      res_q.left_value    <= !sv_show[0] ? '0 :
          (do_write && it_q.slot_position == SlotLeft) ? it_q.token_value : lrd_q;
      res_q.right_value   <= !sv_show[1] ? '0 :
          (do_write && it_q.slot_position == SlotRight) ? it_q.token_value : rrd_q;
      res_q.pred_value    <= !sv_show[2] ? '0 :
          (do_write && it_q.slot_position == SlotPred) ? it_q.token_value : prd_q;
      res_q.store_empty   <= occ_new == '0;
      res_q.store_full    <= {{(CapBits-OccBits){1'b0}}, occ_new} >= eff_cap;
      res_q.erase_missing <= it_q.op == OpErase && !hit_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: rtl/dtms_checker.sv
// ----------------------------------------------------------------------------
// Token matching store checker
// Port-level properties of the token matching store, bound to the top level.
// ----------------------------------------------------------------------------
module dtms_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                done_o,
  input dtms_pkg::out_item_t result_o
);
  import dtms_pkg::*;

  // An accepted item yields a result on done_o after its update step.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> ##1 done_o) else $error("missing result");

  // Busy follows only an accepted item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> $past(start_i) && !$past(busy_o)) else $error("stray busy");

  // A result is never both empty and holding an accepted token.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.accepted |-> !result_o.store_empty)
    else $error("accepted into empty store");

  // Erase miss and acceptance exclude each other.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.accepted && result_o.erase_missing))
    else $error("accept and erase miss together");

endmodule

bind dataflow_token_matching_store dtms_checker u_dtms_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

FILE: bench/tb_dataflow_token_matching_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Token matching store testbench
// Drives accept and erase items with random gaps, predicts each result with
// a behavioral copy of the tag store, and checks every field of every result.
// ----------------------------------------------------------------------------
module tb_dataflow_token_matching_store;
  import dtms_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // Behavioral copy of the store plus the queue of predicted results.
  class match_scoreboard;
    bit                used [Entries];
    bit [TagBits-1:0]  tags [Entries];
    bit [2:0]          vbits [Entries];
    bit [WordBits-1:0] vals [Entries][3];
    int unsigned       occ;
    int unsigned       cap;
    out_item_t         pending[$];
    int unsigned       errors;
    int unsigned       n_acc, n_refused, n_erase, n_missing, n_full;

    function new();
      occ = 0;
      cap = CapReset;
      errors = 0;
    endfunction

    function int unsigned eff_cap();
      return (cap > Entries) ? Entries : cap;
    endfunction

    function int lookup(bit [TagBits-1:0] t);
      for (int i = 0; i < Entries; i++) begin
        if (used[i] && tags[i] == t) return i;
      end
      return -1;
    endfunction

    function void show_entry(int e, ref out_item_t r);
      if (e < 0) return;
      r.left_valid  = vbits[e][0];
      r.right_valid = vbits[e][1];
      r.pred_valid  = vbits[e][2];
      r.left_value  = vbits[e][0] ? vals[e][0] : '0;
      r.right_value = vbits[e][1] ? vals[e][1] : '0;
      r.pred_value  = vbits[e][2] ? vals[e][2] : '0;
    endfunction

    // Apply an accepted item and queue the result it should produce.
    function void note_item(in_item_t it);
      out_item_t        r;
      bit [TagBits-1:0] t;
      int               e;
      t = {it.context_id, it.instr_index};
      e = lookup(t);
      r = '0;
      if (it.op == OpErase) begin
        n_erase++;
        if (e < 0) begin
          r.erase_missing = 1'b1;
          n_missing++;
        end else begin
          show_entry(e, r);
          used[e] = 1'b0;
          vbits[e] = '0;
          occ--;
        end
      end else if (it.slot_position == SlotNone) begin
        show_entry(e, r);
      end else begin
        if (e < 0 && occ < eff_cap()) begin
          for (int i = 0; i < Entries; i++) begin
            if (!used[i]) begin
              e = i;
              used[i] = 1'b1;
              tags[i] = t;
              vbits[i] = '0;
              occ++;
              break;
            end
          end
        end
        if (e >= 0) begin
          vals[e][it.slot_position] = it.token_value;
          vbits[e][it.slot_position] = 1'b1;
          r.accepted = 1'b1;
          n_acc++;
        end else begin
          n_refused++;
        end
        show_entry(e, r);
      end
      r.store_empty = (occ == 0);
      r.store_full  = (occ >= eff_cap());
      if (r.store_full) n_full++;
      pending.push_back(r);
    endfunction

    function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
      errors++;
    endfunction

    // Compare one observed result with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.accepted), 32'h0);
        return;
      end
      w = pending.pop_front();
      if (got.accepted !== w.accepted)
        report_mismatch("accepted", 32'(got.accepted), 32'(w.accepted));
      if (got.left_valid !== w.left_valid)
        report_mismatch("left_valid", 32'(got.left_valid), 32'(w.left_valid));
      if (got.right_valid !== w.right_valid)
        report_mismatch("right_valid", 32'(got.right_valid), 32'(w.right_valid));
      if (got.pred_valid !== w.pred_valid)
        report_mismatch("pred_valid", 32'(got.pred_valid), 32'(w.pred_valid));
      if (got.left_value !== w.left_value)
        report_mismatch("left_value", got.left_value, w.left_value);
      if (got.right_value !== w.right_value)
        report_mismatch("right_value", got.right_value, w.right_value);
      if (got.pred_value !== w.pred_value)
        report_mismatch("pred_value", got.pred_value, w.pred_value);
      if (got.store_empty !== w.store_empty)
        report_mismatch("store_empty", 32'(got.store_empty), 32'(w.store_empty));
      if (got.store_full !== w.store_full)
        report_mismatch("store_full", 32'(got.store_full), 32'(w.store_full));
      if (got.erase_missing !== w.erase_missing)
        report_mismatch("erase_missing", 32'(got.erase_missing), 32'(w.erase_missing));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  in_item_t            item_i;
  logic                busy_o;
  logic                done_o;
  out_item_t           result_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  match_scoreboard sb;
  int unsigned     cycles = 0;
  bit              gaps_on;
  int unsigned     cap_settings;

  dataflow_token_matching_store uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result monitor and run-time limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o === 1'b1) sb.check_result(result_o);
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Write the capacity register; the store must be idle.
  task automatic write_capacity(int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegCapacity;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.cap = value & 5'h1f;
    cap_settings++;
  endtask

  // Present one item and hold it until the store takes it. Start stays high
  // afterwards so that a following item can go out without a gap; a gap or
  // a drain lowers it.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    sb.note_item(it);
  endtask

  // Wait until every predicted result has arrived, then settle.
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(logic op, logic [1:0] slot, logic [31:0] v,
                                         logic [7:0] idx, logic [3:0] ctx);
    in_item_t it;
    it.op = op;
    it.slot_position = slot;
    it.token_value = v;
    it.instr_index = idx;
    it.context_id = ctx;
    return it;
  endfunction

  // Random item drawn mostly from a small tag pool so that tags collide.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned k;
    k = $urandom_range(0, 99);
    it.token_value = $urandom();
    if ($urandom_range(0, 4) == 0) begin
      it.instr_index = 8'($urandom_range(0, 255));
      it.context_id  = 4'($urandom_range(0, 15));
    end else begin
      it.instr_index = {$urandom_range(0, 1) ? 4'hf : 4'h0, 4'($urandom_range(0, 4))};
      it.context_id  = $urandom_range(0, 1) ? 4'hf : 4'($urandom_range(0, 2));
    end
    if (k < 30) begin
      it.op = OpErase;
      it.slot_position = 2'($urandom_range(0, 3));
    end else begin
      it.op = OpAccept;
      it.slot_position = (k < 34) ? SlotNone : 2'($urandom_range(0, 2));
    end
    return it;
  endfunction

  initial begin
    sb = new();
    gaps_on = 1'b1;
    cap_settings = 0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    item_i  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every slot, refusals and erase cases.
    send_item(make_item(OpErase, SlotLeft, 32'h0, 8'h00, 4'h0));
    send_item(make_item(OpAccept, SlotLeft, 32'hffff_ffff, 8'hff, 4'hf));
    send_item(make_item(OpAccept, SlotRight, 32'h0, 8'hff, 4'hf));
    send_item(make_item(OpAccept, SlotPred, 32'ha5a5_5a5a, 8'hff, 4'hf));
    send_item(make_item(OpAccept, SlotNone, 32'h1234_5678, 8'hff, 4'hf));
    send_item(make_item(OpAccept, SlotNone, 32'h1, 8'h00, 4'h0));
    send_item(make_item(OpAccept, SlotLeft, 32'h1, 8'h00, 4'h0));
    send_item(make_item(OpAccept, SlotLeft, 32'h2, 8'h00, 4'h0));
    send_item(make_item(OpErase, SlotNone, 32'hffff_ffff, 8'hff, 4'hf));
    send_item(make_item(OpErase, SlotPred, 32'h0, 8'hff, 4'hf));
    drain();

    // Capacity one: a second tag is refused; lowering below occupancy.
    write_capacity(1);
    send_item(make_item(OpAccept, SlotRight, 32'h5555_aaaa, 8'h01, 4'h0));
    send_item(make_item(OpAccept, SlotPred, 32'h7, 8'h00, 4'h0));
    drain();
    write_capacity(2);
    send_item(make_item(OpAccept, SlotLeft, 32'h9, 8'h01, 4'h0));
    drain();
    write_capacity(1);
    send_item(make_item(OpAccept, SlotRight, 32'h3, 8'h01, 4'h0));
    send_item(make_item(OpAccept, SlotLeft, 32'h4, 8'h02, 4'h0));
    send_item(make_item(OpErase, SlotLeft, 32'h0, 8'h01, 4'h0));
    drain();
    // Zero capacity: every new tag refused, old tag still matches.
    write_capacity(0);
    send_item(make_item(OpAccept, SlotLeft, 32'h8, 8'h03, 4'h0));
    send_item(make_item(OpAccept, SlotRight, 32'h8, 8'h00, 4'h0));
    send_item(make_item(OpErase, SlotLeft, 32'h0, 8'h00, 4'h0));
    drain();
    // Register values above the entry count saturate.
    write_capacity(31);

    // Random phases over several capacities, last phase without gaps.
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) gaps_on = 1'b0;
      for (int n = 0; n < 100; n++) send_item(random_item());
      // Hold off once until the store has answered everything.
      drain();
      if (ph == 2) write_capacity(16);
      else if (ph < 6) write_capacity($urandom_range(0, 31));
    end
    drain();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d capacity settings, %0d accepts, %0d refusals, %0d full results.",
             cap_settings, sb.n_acc, sb.n_refused, sb.n_full);
    $display("Erases: %0d, of which %0d named a missing tag.", sb.n_erase, sb.n_missing);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dtms_pkg.sv
rtl/dataflow_token_matching_store.sv
rtl/dtms_checker.sv
bench/tb_dataflow_token_matching_store.sv
